@@ rtl/core/ffba_pkg.sv @@
`default_nettype none
package ffba_pkg;

    localparam int SIZE_W = 27;
    localparam int ADDR_W = 32;
    localparam int HDR_W  = 7;
    localparam int STAT_W = 11;

    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_ZERO   = 2'd1;
    localparam logic [1:0] KIND_FREE   = 2'd2;
    localparam logic [1:0] KIND_RESIZE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SIZE    = 2'd1;
    localparam logic [1:0] ST_HEAP    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic [1:0] REG_LIMIT    = 2'd0;
    localparam logic [1:0] REG_HEADER   = 2'd1;
    localparam logic [1:0] REG_CAPACITY = 2'd2;

    localparam logic [SIZE_W-1:0] LIMIT_RESET    = 27'd100000000;
    localparam logic [HDR_W-1:0]  HEADER_RESET   = 7'd32;
    localparam logic [ADDR_W-1:0] CAPACITY_RESET = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_SCAN_FIND,
        S_FOUND,
        S_SCAN_ALLOC,
        S_TAKE,
        S_APPEND,
        S_RELEASE,
        S_FINISH
    } ffba_state_t;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       scan_start;
        logic       scan_alloc;
        logic       scan_step;
        logic       take;
        logic       append;
        logic       release_hit;
        logic       claim_hit;
        logic       save_old;
        logic       release_old;
        logic       set_status;
        logic [1:0] status;
        logic       finish;
    } ffba_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       bad_size;
        logic       addr_null;
        logic       hit;
        logic       miss;
        logic       hit_free;
        logic       fits_in_place;
        logic       append_ok;
        logic       old_valid;
        logic       counts_ok;
    } ffba_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/ffba_ctrl.sv @@
`default_nettype none
module ffba_ctrl
    import ffba_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_kind,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire ffba_stat_t stat,
    output ffba_cmd_t       cmd
);

    ffba_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (in_kind == KIND_ZERO) ? S_MUL : S_CHECK;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (stat.kind == KIND_FREE) begin
                    if (stat.addr_null) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_IGNORED;
                        state_next     = S_FINISH;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN_FIND;
                    end
                end else if (stat.bad_size) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_SIZE;
                    state_next     = S_FINISH;
                end else if (stat.kind == KIND_RESIZE && !stat.addr_null) begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN_FIND;
                end else begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_alloc = 1'b1;
                    state_next     = S_SCAN_ALLOC;
                end
            end
            S_SCAN_FIND: begin
                cmd.scan_step = 1'b1;
                if (stat.hit) begin
                    state_next = S_FOUND;
                end else if (stat.miss) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_IGNORED;
                    state_next     = S_FINISH;
                end
            end
            S_FOUND: begin
                cmd.set_status = 1'b1;
                cmd.status     = ST_OK;
                state_next     = S_FINISH;
                if (stat.kind == KIND_FREE) begin
                    if (stat.hit_free) begin
                        cmd.status = ST_IGNORED;
                    end else begin
                        cmd.release_hit = 1'b1;
                    end
                end else if (stat.fits_in_place) begin
                    cmd.claim_hit = 1'b1;
                end else begin
                    cmd.set_status = 1'b0;
                    cmd.save_old   = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.scan_alloc = 1'b1;
                    state_next     = S_SCAN_ALLOC;
                end
            end
            S_SCAN_ALLOC: begin
                cmd.scan_step = 1'b1;
                cmd.scan_alloc = 1'b1;
                if (stat.hit) begin
                    state_next = S_TAKE;
                end else if (stat.miss) begin
                    state_next = S_APPEND;
                end
            end
            S_TAKE: begin
                cmd.take       = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_OK;
                state_next     = stat.old_valid ? S_RELEASE : S_FINISH;
            end
            S_APPEND: begin
                cmd.set_status = 1'b1;
                if (stat.append_ok) begin
                    cmd.append = 1'b1;
                    cmd.status = ST_OK;
                    state_next = stat.old_valid ? S_RELEASE : S_FINISH;
                end else begin
                    cmd.status = ST_HEAP;
                    state_next = S_FINISH;
                end
            end
            S_RELEASE: begin
                cmd.release_old = 1'b1;
                state_next      = S_FINISH;
            end
            S_FINISH: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

@@ rtl/core/ffba_dpath.sv @@
`default_nettype none
module ffba_dpath
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS        = 64,
    parameter int HEAP_ADDRESS_BITS = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SIZE_W-1:0] cfg_limit,
    input  wire logic [HDR_W-1:0]  cfg_header,
    input  wire logic [ADDR_W-1:0] cfg_capacity,
    input  wire logic [1:0]        kind,
    input  wire logic [SIZE_W-1:0] request_size,
    input  wire logic [SIZE_W-1:0] element_count,
    input  wire logic [ADDR_W-1:0] block_address,
    input  wire ffba_cmd_t         cmd,
    output ffba_stat_t             stat,
    output logic [1:0]             status,
    output logic [ADDR_W-1:0]      result_address,
    output logic [ADDR_W-1:0]      move_from,
    output logic [SIZE_W-1:0]      move_bytes,
    output logic [SIZE_W-1:0]      zero_fill_bytes,
    output logic [STAT_W-1:0]      free_block_total,
    output logic [ADDR_W-1:0]      free_byte_total,
    output logic [STAT_W-1:0]      block_total,
    output logic [ADDR_W-1:0]      byte_total
);

    localparam int IW      = $clog2(MAX_BLOCKS);
    localparam int CW      = $clog2(MAX_BLOCKS + 1);
    localparam int ENTRY_W = SIZE_W + 1 + ADDR_W;
    localparam int PROD_W  = 2 * SIZE_W;
    localparam int TOP_W   = ADDR_W + 2;
    localparam logic [48:0] ADDR_MAX = (49'd1 << HEAP_ADDRESS_BITS) - 49'd1;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_BLOCKS);

    // table memory: {size, free, address}
    logic [ENTRY_W-1:0] mem [MAX_BLOCKS];
    logic [ENTRY_W-1:0] mem_q_reg;

    logic [1:0]        kind_reg;
    logic [SIZE_W-1:0] size_reg, count_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [CW-1:0]     rd_idx_reg;
    logic              chk_valid_reg;
    logic [IW-1:0]     chk_idx_reg;
    logic              mode_alloc_reg;

    logic [IW-1:0]     hit_idx_reg;
    logic [SIZE_W-1:0] hit_size_reg;
    logic              hit_free_reg;
    logic [ADDR_W-1:0] hit_addr_reg;

    logic              old_valid_reg;
    logic [IW-1:0]     old_idx_reg;
    logic [SIZE_W-1:0] old_size_reg;
    logic              old_free_reg;

    logic [CW-1:0]     entry_count_reg;
    logic [CW-1:0]     free_entries_reg;
    logic [ADDR_W-1:0] heap_top_reg;
    logic [ADDR_W-1:0] free_bytes_reg;
    logic [ADDR_W-1:0] used_bytes_reg;

    logic [ADDR_W-1:0] res_addr_reg;
    logic [ADDR_W-1:0] mfrom_reg;
    logic [SIZE_W-1:0] mbytes_reg;
    logic [SIZE_W-1:0] zfill_reg;
    logic [1:0]        status_reg;

    logic [1:0]        out_status_reg;
    logic [ADDR_W-1:0] out_result_reg, out_mfrom_reg, out_free_bytes_reg, out_used_bytes_reg;
    logic [SIZE_W-1:0] out_mbytes_reg, out_zfill_reg;
    logic [CW-1:0]     out_free_cnt_reg, out_count_reg;

    logic [SIZE_W-1:0] q_size;
    logic              q_free;
    logic [ADDR_W-1:0] q_addr;
    logic              match, hit, miss;
    logic [SIZE_W-1:0] req;
    logic              bad_size;
    logic [HDR_W-1:0]  hdr;
    logic [TOP_W-1:0]  new_top;
    logic [48:0]       limit;
    logic              append_ok;
    logic              we;
    logic [IW-1:0]     widx;
    logic [ENTRY_W-1:0] wdata;

    assign q_size = mem_q_reg[ENTRY_W-1 -: SIZE_W];
    assign q_free = mem_q_reg[ADDR_W];
    assign q_addr = mem_q_reg[ADDR_W-1:0];

    assign match = mode_alloc_reg ? (q_free && q_size >= req) : (q_addr == addr_reg);
    assign hit   = chk_valid_reg && match;
    assign miss  = !chk_valid_reg && (rd_idx_reg >= entry_count_reg);

    always_comb begin
        if (kind_reg == KIND_ZERO) begin
            req      = prod_reg[SIZE_W-1:0];
            bad_size = (prod_reg == '0) || (prod_reg > PROD_W'(cfg_limit));
        end else begin
            req      = size_reg;
            bad_size = (size_reg == '0) || (size_reg > cfg_limit);
        end
    end

    // append: header of zero counts as one byte
    assign hdr     = (cfg_header == '0) ? HDR_W'(1) : cfg_header;
    assign new_top = TOP_W'(heap_top_reg) + TOP_W'(hdr) + TOP_W'(req);
    assign limit   = (ADDR_MAX < 49'(cfg_capacity)) ? ADDR_MAX : 49'(cfg_capacity);
    assign append_ok = (entry_count_reg < MAX_COUNT) && !(49'(new_top) > limit);

    always_comb begin
        we    = 1'b0;
        widx  = hit_idx_reg;
        wdata = {hit_size_reg, 1'b0, hit_addr_reg};
        if (cmd.take) begin
            we = 1'b1;
        end else if (cmd.append) begin
            we    = 1'b1;
            widx  = entry_count_reg[IW-1:0];
            wdata = {req, 1'b0, heap_top_reg + ADDR_W'(hdr)};
        end else if (cmd.release_hit) begin
            we    = 1'b1;
            wdata = {hit_size_reg, 1'b1, hit_addr_reg};
        end else if (cmd.claim_hit) begin
            we = hit_free_reg;
        end else if (cmd.release_old) begin
            we    = !old_free_reg;
            widx  = old_idx_reg;
            wdata = {old_size_reg, 1'b1, addr_reg};
        end
    end

    always_ff @(posedge clk) begin
        if (we) begin
            mem[widx] <= wdata;
        end
        mem_q_reg <= mem[rd_idx_reg[IW-1:0]];
    end

    // request payload and scan bookkeeping
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            kind_reg  <= kind;
            size_reg  <= request_size;
            count_reg <= element_count;
            addr_reg  <= block_address;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(count_reg) * PROD_W'(size_reg);
        end
        if (cmd.scan_start) begin
            mode_alloc_reg <= cmd.scan_alloc;
        end
        if (cmd.scan_step && hit) begin
            hit_idx_reg  <= chk_idx_reg;
            hit_size_reg <= q_size;
            hit_free_reg <= q_free;
            hit_addr_reg <= q_addr;
        end
        if (cmd.save_old) begin
            old_idx_reg  <= hit_idx_reg;
            old_size_reg <= hit_size_reg;
            old_free_reg <= hit_free_reg;
        end
        if (cmd.finish) begin
            out_status_reg     <= status_reg;
            out_result_reg     <= (status_reg == ST_OK) ? res_addr_reg : '0;
            out_mfrom_reg      <= mfrom_reg;
            out_mbytes_reg     <= mbytes_reg;
            out_zfill_reg      <= zfill_reg;
            out_free_cnt_reg   <= free_entries_reg;
            out_free_bytes_reg <= free_bytes_reg;
            out_count_reg      <= entry_count_reg;
            out_used_bytes_reg <= used_bytes_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rd_idx_reg       <= '0;
            chk_valid_reg    <= 1'b0;
            chk_idx_reg      <= '0;
            old_valid_reg    <= 1'b0;
            entry_count_reg  <= '0;
            free_entries_reg <= '0;
            heap_top_reg     <= '0;
            free_bytes_reg   <= '0;
            used_bytes_reg   <= '0;
            res_addr_reg     <= '0;
            mfrom_reg        <= '0;
            mbytes_reg       <= '0;
            zfill_reg        <= '0;
            status_reg       <= ST_OK;
        end else begin
            if (cmd.load) begin
                old_valid_reg <= 1'b0;
                res_addr_reg  <= '0;
                mfrom_reg     <= '0;
                mbytes_reg    <= '0;
                zfill_reg     <= '0;
            end
            if (cmd.scan_start) begin
                rd_idx_reg    <= '0;
                chk_valid_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                if (hit || rd_idx_reg >= entry_count_reg) begin
                    chk_valid_reg <= 1'b0;
                end else begin
                    rd_idx_reg    <= rd_idx_reg + CW'(1);
                    chk_valid_reg <= 1'b1;
                    chk_idx_reg   <= rd_idx_reg[IW-1:0];
                end
            end
            if (cmd.save_old) begin
                old_valid_reg <= 1'b1;
            end
            if (cmd.set_status) begin
                status_reg <= cmd.status;
            end
            if (cmd.take) begin
                free_entries_reg <= free_entries_reg - CW'(1);
                free_bytes_reg   <= free_bytes_reg - ADDR_W'(hit_size_reg);
                res_addr_reg     <= hit_addr_reg;
                if (kind_reg == KIND_ZERO) begin
                    zfill_reg <= req;
                end
            end
            if (cmd.append) begin
                entry_count_reg <= entry_count_reg + CW'(1);
                heap_top_reg    <= new_top[ADDR_W-1:0];
                used_bytes_reg  <= used_bytes_reg + ADDR_W'(req);
                res_addr_reg    <= heap_top_reg + ADDR_W'(hdr);
                if (kind_reg == KIND_ZERO) begin
                    zfill_reg <= req;
                end
            end
            if (cmd.release_hit) begin
                free_entries_reg <= free_entries_reg + CW'(1);
                free_bytes_reg   <= free_bytes_reg + ADDR_W'(hit_size_reg);
            end
            if (cmd.claim_hit) begin
                res_addr_reg <= addr_reg;
                if (hit_free_reg) begin
                    free_entries_reg <= free_entries_reg - CW'(1);
                    free_bytes_reg   <= free_bytes_reg - ADDR_W'(hit_size_reg);
                end
            end
            if (cmd.release_old) begin
                mfrom_reg  <= addr_reg;
                mbytes_reg <= old_size_reg;
                if (!old_free_reg) begin
                    free_entries_reg <= free_entries_reg + CW'(1);
                    free_bytes_reg   <= free_bytes_reg + ADDR_W'(old_size_reg);
                end
            end
        end
    end

    always_comb begin
        stat.kind          = kind_reg;
        stat.bad_size      = bad_size;
        stat.addr_null     = (addr_reg == '0);
        stat.hit           = hit;
        stat.miss          = miss;
        stat.hit_free      = hit_free_reg;
        stat.fits_in_place = (size_reg <= hit_size_reg);
        stat.append_ok     = append_ok;
        stat.old_valid     = old_valid_reg;
        stat.counts_ok     = (free_entries_reg <= entry_count_reg)
                             && (entry_count_reg <= MAX_COUNT);
    end

    assign status           = out_status_reg;
    assign result_address   = out_result_reg;
    assign move_from        = out_mfrom_reg;
    assign move_bytes       = out_mbytes_reg;
    assign zero_fill_bytes  = out_zfill_reg;
    assign free_block_total = STAT_W'(out_free_cnt_reg);
    assign free_byte_total  = out_free_bytes_reg;
    assign block_total      = STAT_W'(out_count_reg);
    assign byte_total       = out_used_bytes_reg;

endmodule
`default_nettype wire

@@ rtl/core/first_fit_block_allocator.sv @@
`default_nettype none
// First-fit heap block allocator. Each request (allocate, zeroed allocate,
// free, resize) returns exactly one result with a status, the payload address
// handed out, the copy range for a resize, the zero-fill length for a zeroed
// allocate and running block/byte statistics. The block table lives in a
// memory with one read and one write port that is scanned one entry per
// cycle; a resize that must move its block scans the table twice, and a
// zeroed allocate adds a multiply step. A new request is taken once the
// previous one has reached the output register, so a waiting result does not
// block the next request. Table contents need no clearing after reset;
// configuration (limit, header size, heap capacity) must be written through
// the APB port only while no request is in flight; the block itself does not
// enforce this.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS        = 64,
    parameter int HEAP_ADDRESS_BITS = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // request channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        kind,
    input  wire logic [SIZE_W-1:0] request_size,
    input  wire logic [SIZE_W-1:0] element_count,
    input  wire logic [ADDR_W-1:0] block_address,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             status,
    output logic [ADDR_W-1:0]      result_address,
    output logic [ADDR_W-1:0]      move_from,
    output logic [SIZE_W-1:0]      move_bytes,
    output logic [SIZE_W-1:0]      zero_fill_bytes,
    output logic [STAT_W-1:0]      free_block_total,
    output logic [ADDR_W-1:0]      free_byte_total,
    output logic [STAT_W-1:0]      block_total,
    output logic [ADDR_W-1:0]      byte_total
);

    logic [SIZE_W-1:0] limit_reg;
    logic [HDR_W-1:0]  header_reg;
    logic [ADDR_W-1:0] capacity_reg;
    logic              cfg_write;
    logic [1:0]        reg_index;
    ffba_cmd_t         cmd;
    ffba_stat_t        stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    // Write the addressed register in the access phase; drop writes past the list.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            limit_reg    <= LIMIT_RESET;
            header_reg   <= HEADER_RESET;
            capacity_reg <= CAPACITY_RESET;
        end else if (cfg_write) begin
            case (reg_index)
                REG_LIMIT:    limit_reg    <= pwdata[SIZE_W-1:0];
                REG_HEADER:   header_reg   <= pwdata[HDR_W-1:0];
                REG_CAPACITY: capacity_reg <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_LIMIT:    prdata = 32'(limit_reg);
            REG_HEADER:   prdata = 32'(header_reg);
            REG_CAPACITY: prdata = capacity_reg;
            default:      prdata = '0;
        endcase
    end

    // Sequence each request: latch, multiply (zeroed allocate), check, scan, update, then hand over.
    ffba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_kind   (kind),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the table memory, running totals and the result register.
    ffba_dpath #(
        .MAX_BLOCKS        (MAX_BLOCKS),
        .HEAP_ADDRESS_BITS (HEAP_ADDRESS_BITS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_limit        (limit_reg),
        .cfg_header       (header_reg),
        .cfg_capacity     (capacity_reg),
        .kind             (kind),
        .request_size     (request_size),
        .element_count    (element_count),
        .block_address    (block_address),
        .cmd              (cmd),
        .stat             (stat),
        .status           (status),
        .result_address   (result_address),
        .move_from        (move_from),
        .move_bytes       (move_bytes),
        .zero_fill_bytes  (zero_fill_bytes),
        .free_block_total (free_block_total),
        .free_byte_total  (free_byte_total),
        .block_total      (block_total),
        .byte_total       (byte_total)
    );

`ifndef ASSERT_OFF
    // A taken request closes the input until its result is registered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in flight");

    // Free entries never outnumber table entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.counts_ok)
        else $error("free entry count exceeds table entry count");

    // A scan never reports a hit and a miss together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.hit && stat.miss))
        else $error("scan hit and miss at once");

    // The result register only loads once the output side is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid || out_ready))
        else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire
